// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers used across the unescaper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define AM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define AM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Shared types and codes for the front decoder, job queue and result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

   typedef enum logic [1:0] {
      PH_SEEK = 2'd0,
      PH_BODY = 2'd1,
      PH_ESC  = 2'd2,
      PH_HEX  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   localparam logic [2:0] ERR_EXPECT_STRING  = 3'd0;
   localparam logic [2:0] ERR_CONTROL        = 3'd1;
   localparam logic [2:0] ERR_UNTERM_ESCAPE  = 3'd2;
   localparam logic [2:0] ERR_INCOMPLETE_HEX = 3'd3;
   localparam logic [2:0] ERR_BAD_HEX        = 3'd4;
   localparam logic [2:0] ERR_SURROGATE      = 3'd5;
   localparam logic [2:0] ERR_BAD_ESCAPE     = 3'd6;
   localparam logic [2:0] ERR_UNTERM_STRING  = 3'd7;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   // One queued job: all results caused by one input byte.
   typedef struct packed {
      logic [1:0]       count;    // number of result beats, 1 to 3
      kind_type         kind;
      logic [2:0]       err;
      logic [2:0][7:0]  bytes;    // data byte of each beat, beat 0 in the low byte
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// File: rtl/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// JSON string unescaper with UTF-8 output
// Byte-stream parser that decodes JSON string bodies into UTF-8 bytes.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  req_     in         tdata[7:0] in_byte, tuser end_of_text
//  rsp_     out        tdata[7:0] out_byte, tdata[10:8] error_code,
//                      tuser kind, tlast last_of_run
//
//  The block takes a byte every cycle while the result side keeps up and
//  the job queue is not full.
//  A completed \uXXXX escape above 0x7F gives two or three UTF-8 beats, and
//  the result sequencer sends them one beat at a time, so such a byte costs
//  more output bandwidth than input; the two-job queue absorbs the difference.
//  Reset is synchronous and active high and returns the parser to seeking
//  an opening quote with an empty queue and no result pending.
//  req_tready drops only while the job queue is full.
//
// The front end classifies each byte against the parser state (seeking,
// string body, after a backslash, collecting hex digits) and packs all of
// the results that byte causes into one job. The job queue holds up to two
// jobs, and the result sequencer unrolls each job into beats through an
// output register, flagging the final beat of each job with tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_top (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] in_byte
   input  wire logic         req_tuser,   // [0] end_of_text

   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
   output logic [1:0]        rsp_tuser,   // [1:0] kind
   output logic              rsp_tlast    // last_of_run
);

   jsu_pkg::job_type           push_job;
   jsu_pkg::job_type           head_job;
   jsu_pkg::queue_status_type  q_status;
   logic                       push;
   logic                       pop;
   logic                       accept;
   logic [7:0]                 out_byte;
   logic [2:0]                 error_code;

   // The parser advances on every accepted beat; the queue only needs room
   // when the beat produces results, but a single check keeps timing short.
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_tdata),
      .end_of_text (req_tuser),
      .job         (push_job),
      .push        (push)
   );

   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .status     (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_byte   (out_byte),
      .rsp_err    (error_code),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'b00000, error_code, out_byte};

endmodule

`default_nettype wire

// File: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// JSON string unescaper front end
// Runs the string parser per input byte and turns each byte into a job.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jsu_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        in_byte,
   input  wire logic              end_of_text,
   output jsu_pkg::job_type       job,
   output logic                   push
);

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;

   jsu_pkg::phase_type phase_ff, phase_in;
   logic [15:0] cp_ff, cp_in;
   logic [1:0]  hc_ff, hc_in;
   logic        hb_ff, hb_in;

   logic [3:0]  digit;
   logic        digit_bad;
   logic [15:0] cp_next;
   logic        hb_now;

   function automatic jsu_pkg::job_type make_err(input logic [2:0] code);
      jsu_pkg::job_type j;
      j       = '0;
      j.count = 2'd1;
      j.kind  = jsu_pkg::KIND_ERR;
      j.err   = code;
      return j;
   endfunction

   function automatic jsu_pkg::job_type make_data(input logic [7:0] b);
      jsu_pkg::job_type j;
      j          = '0;
      j.count    = 2'd1;
      j.kind     = jsu_pkg::KIND_DATA;
      j.bytes[0] = b;
      return j;
   endfunction

   // Hex digit value; a non-hex character counts as zero and is flagged.
   always_comb begin
      digit_bad = 1'b0;
      digit     = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         digit = in_byte[3:0];
      end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                   (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
         digit = in_byte[3:0] + 4'd9;
      end else begin
         digit_bad = 1'b1;
      end
   end

   assign cp_next = {cp_ff[11:0], digit};
   assign hb_now  = hb_ff | digit_bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsu_pkg::PH_SEEK;
         cp_ff    <= '0;
         hc_ff    <= '0;
         hb_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cp_ff    <= cp_in;
         hc_ff    <= hc_in;
         hb_ff    <= hb_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cp_in    = cp_ff;
      hc_in    = hc_ff;
      hb_in    = hb_ff;
      job      = '0;
      unique case (phase_ff)
         jsu_pkg::PH_SEEK: begin
            if (end_of_text) begin
               job = make_err(jsu_pkg::ERR_EXPECT_STRING);
            end else if (in_byte == CH_SPACE || in_byte == CH_TAB ||
                         in_byte == CH_CR || in_byte == CH_LF) begin
               job = '0;
            end else if (in_byte == CH_QUOTE) begin
               phase_in = jsu_pkg::PH_BODY;
            end else begin
               job = make_err(jsu_pkg::ERR_EXPECT_STRING);
            end
         end
         jsu_pkg::PH_BODY: begin
            if (end_of_text) begin
               job      = make_err(jsu_pkg::ERR_UNTERM_STRING);
               phase_in = jsu_pkg::PH_SEEK;
            end else if (in_byte == CH_QUOTE) begin
               job       = '0;
               job.count = 2'd1;
               job.kind  = jsu_pkg::KIND_DONE;
               phase_in  = jsu_pkg::PH_SEEK;
            end else if (in_byte < CH_SPACE) begin
               job      = make_err(jsu_pkg::ERR_CONTROL);
               phase_in = jsu_pkg::PH_SEEK;
            end else if (in_byte == CH_BACKSLASH) begin
               phase_in = jsu_pkg::PH_ESC;
            end else begin
               job = make_data(in_byte);
            end
         end
         jsu_pkg::PH_ESC: begin
            phase_in = jsu_pkg::PH_BODY;
            if (end_of_text) begin
               job      = make_err(jsu_pkg::ERR_UNTERM_ESCAPE);
               phase_in = jsu_pkg::PH_SEEK;
            end else begin
               unique case (in_byte) inside
                  CH_QUOTE, CH_BACKSLASH, CH_SLASH: job = make_data(in_byte);
                  CH_B: job = make_data(8'h08);
                  CH_F: job = make_data(8'h0C);
                  CH_N: job = make_data(8'h0A);
                  CH_R: job = make_data(8'h0D);
                  CH_T: job = make_data(8'h09);
                  CH_U: begin
                     phase_in = jsu_pkg::PH_HEX;
                     cp_in    = '0;
                     hc_in    = '0;
                     hb_in    = 1'b0;
                  end
                  default: begin
                     job      = make_err(jsu_pkg::ERR_BAD_ESCAPE);
                     phase_in = jsu_pkg::PH_SEEK;
                  end
               endcase
            end
         end
         jsu_pkg::PH_HEX: begin
            if (end_of_text) begin
               job      = make_err(jsu_pkg::ERR_INCOMPLETE_HEX);
               phase_in = jsu_pkg::PH_SEEK;
            end else begin
               cp_in = cp_next;
               hb_in = hb_now;
               if (hc_ff != 2'd3) begin
                  hc_in = hc_ff + 2'd1;
               end else begin
                  hc_in = 2'd0;
                  if (hb_now) begin
                     job      = make_err(jsu_pkg::ERR_BAD_HEX);
                     phase_in = jsu_pkg::PH_SEEK;
                  end else if (cp_next >= 16'hD800 && cp_next <= 16'hDFFF) begin
                     job      = make_err(jsu_pkg::ERR_SURROGATE);
                     phase_in = jsu_pkg::PH_SEEK;
                  end else begin
                     phase_in = jsu_pkg::PH_BODY;
                     job      = '0;
                     job.kind = jsu_pkg::KIND_DATA;
                     if (cp_next <= 16'h007F) begin
                        job.count    = 2'd1;
                        job.bytes[0] = cp_next[7:0];
                     end else if (cp_next <= 16'h07FF) begin
                        job.count    = 2'd2;
                        job.bytes[0] = {3'b110, cp_next[10:6]};
                        job.bytes[1] = {2'b10, cp_next[5:0]};
                     end else begin
                        job.count    = 2'd3;
                        job.bytes[0] = {4'b1110, cp_next[15:12]};
                        job.bytes[1] = {2'b10, cp_next[11:6]};
                        job.bytes[2] = {2'b10, cp_next[5:0]};
                     end
                  end
               end
            end
         end
         default: phase_in = jsu_pkg::PH_SEEK;
      endcase
   end

   assign push = accept && (job.count != 2'd0);

   // Only the completion of a unicode escape can give more than one result.
   `AM_ASSERT(a_multi_only_from_hex, clock, reset,
      (accept && job.count > 2'd1) |-> (phase_ff == jsu_pkg::PH_HEX && hc_ff == 2'd3),
      "multi-beat job outside a completed unicode escape")
   // An accepted 'u' escape starts digit collection from a clean slate.
   `AM_ASSERT(a_hex_start_clean, clock, reset,
      (accept && phase_ff == jsu_pkg::PH_ESC && !end_of_text && in_byte == CH_U)
         |=> (phase_ff == jsu_pkg::PH_HEX && hc_ff == 2'd0 && !hb_ff),
      "unicode escape did not start clean")

endmodule

`default_nettype wire

// File: rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// JSON string unescaper job queue
// Short register FIFO that decouples the parser from the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jsu_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire jsu_pkg::job_type      push_job,
   input  wire logic                  pop,
   output jsu_pkg::job_type           head_job,
   output jsu_pkg::queue_status_type  status
);

   localparam int CNT_W = $clog2(jsu_pkg::QUEUE_DEPTH + 1);

   jsu_pkg::job_type slot_ff [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [jsu_pkg::QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   assign head_job     = slot_ff[rd_ff];
   assign status.full  = (cnt_ff == CNT_W'(jsu_pkg::QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);

   `AM_ASSERT(a_no_overflow, clock, reset, push |-> (!status.full),
      "job pushed into a full queue")
   `AM_ASSERT(a_no_underflow, clock, reset, pop |-> (!status.empty),
      "job popped from an empty queue")

endmodule

`default_nettype wire

// File: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// JSON string unescaper result sequencer
// Unrolls each queued job into result beats through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jsu_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire jsu_pkg::job_type      head_job,
   input  wire jsu_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [1:0]                 rsp_kind,
   output logic [7:0]                 rsp_byte,
   output logic [2:0]                 rsp_err,
   output logic                       rsp_last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff;
   logic [2:0] err_ff;
   logic       last_ff;

   logic       load;
   logic       beat_last;
   logic [7:0] beat_byte;

   assign load      = !status.empty && (!valid_ff || rsp_tready);
   assign beat_last = (idx_ff == head_job.count - 2'd1);
   assign pop       = load && beat_last;

   always_comb begin
      case (idx_ff)
         2'd0:    beat_byte = head_job.bytes[0];
         2'd1:    beat_byte = head_job.bytes[1];
         2'd2:    beat_byte = head_job.bytes[2];
         default: beat_byte = 8'h00;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = beat_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= head_job.kind;
         byte_ff <= beat_byte;
         err_ff  <= head_job.err;
         last_ff <= beat_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_byte   = byte_ff;
   assign rsp_err    = err_ff;
   assign rsp_last   = last_ff;

   // The beat index never runs past the three beats a job can hold.
   `AM_ASSERT_ALWAYS(a_idx_range, clock, reset || idx_ff != 2'd3,
      "beat index out of range")
   // A job leaves the queue exactly when its final beat is loaded.
   `AM_ASSERT(a_pop_marks_last, clock, reset, pop |=> (valid_ff && last_ff),
      "job popped without its final beat in the output register")

endmodule

`default_nettype wire

// File: dv/tb_json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// JSON string unescaper testbench
// Drives byte beats into the unescaper and checks every result beat against
// an in-bench parser model: seeking, string body, escapes, \uXXXX to UTF-8,
// and all error codes. The run goes from directed text to random strings.
// ----------------------------------------------------------------------------

module tb_json_string_unescape_utf8_top;

   // Characters that steer the parser.
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_LAST_CTRL = 8'h1F;

   // Error field value carried by data and done beats.
   localparam logic [2:0] NO_ERROR = 3'd0;

   // One result beat as the parser model predicts it.
   typedef struct {
      jsu_pkg::kind_type kind;
      logic [7:0]        data;
      logic [2:0]        err;
      logic              last;
   } decoded_beat_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_byte
   logic        req_tuser;   // [0] end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] out_byte, [10:8] error_code, [15:11] zero
   logic [1:0]  rsp_tuser;   // [1:0] kind
   logic        rsp_tlast;   // last_of_run

   // Parser model state, mirroring the block after each accepted byte.
   jsu_pkg::phase_type parse_phase;
   logic [15:0] cp_accum;
   logic [1:0]  hex_seen;
   logic        hex_invalid;

   decoded_beat_type beats_due[$];   // results still owed by the block, oldest first
   decoded_beat_type run_beats[$];   // results of the byte being modeled
   int          error_count = 0;
   int          items_sent = 0;
   bit          idle_enable = 1'b1;

   json_string_unescape_utf8_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------------------------------------------------------------
   // Parser model
   // ---------------------------------------------------------------------

   // Bit 4 flags a valid hex digit; bits 3:0 hold its value.
   function automatic logic [4:0] hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
      if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
      return 5'd0;
   endfunction

   function automatic void emit(jsu_pkg::kind_type k, logic [7:0] d, logic [2:0] e);
      decoded_beat_type bt;
      bt.kind = k;
      bt.data = d;
      bt.err  = e;
      bt.last = 1'b0;
      run_beats = {run_beats, bt};
   endfunction

   // Every error inside a string sends the parser back to seeking, and so
   // does an error while seeking, so one helper covers them all.
   function automatic void emit_error(logic [2:0] code);
      emit(jsu_pkg::KIND_ERR, 8'h00, code);
      parse_phase = jsu_pkg::PH_SEEK;
   endfunction

   function automatic void emit_utf8(logic [15:0] cp);
      if (cp <= 16'h007F) begin
         emit(jsu_pkg::KIND_DATA, cp[7:0], NO_ERROR);
      end else if (cp <= 16'h07FF) begin
         emit(jsu_pkg::KIND_DATA, {3'b110, cp[10:6]}, NO_ERROR);
         emit(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, NO_ERROR);
      end else begin
         emit(jsu_pkg::KIND_DATA, {4'b1110, cp[15:12]}, NO_ERROR);
         emit(jsu_pkg::KIND_DATA, {2'b10, cp[11:6]}, NO_ERROR);
         emit(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, NO_ERROR);
      end
   endfunction

   // Advances the model by one accepted byte beat and queues its results,
   // with tlast set on the final one.
   function automatic void predict_unescape(logic [7:0] c, logic eot);
      logic [4:0] hv;
      case (parse_phase)
         jsu_pkg::PH_SEEK: begin
            if (eot) emit_error(jsu_pkg::ERR_EXPECT_STRING);
            else if (c == CH_QUOTE) parse_phase = jsu_pkg::PH_BODY;
            else if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF))
               emit_error(jsu_pkg::ERR_EXPECT_STRING);
         end
         jsu_pkg::PH_BODY: begin
            if (eot) begin
               emit_error(jsu_pkg::ERR_UNTERM_STRING);
            end else if (c == CH_QUOTE) begin
               emit(jsu_pkg::KIND_DONE, 8'h00, NO_ERROR);
               parse_phase = jsu_pkg::PH_SEEK;
            end else if (c < 8'h20) begin
               emit_error(jsu_pkg::ERR_CONTROL);
            end else if (c == CH_BACKSLASH) begin
               parse_phase = jsu_pkg::PH_ESC;
            end else begin
               emit(jsu_pkg::KIND_DATA, c, NO_ERROR);
            end
         end
         jsu_pkg::PH_ESC: begin
            if (eot) begin
               emit_error(jsu_pkg::ERR_UNTERM_ESCAPE);
            end else if (c == CH_U) begin
               parse_phase = jsu_pkg::PH_HEX;
               cp_accum    = 16'h0000;
               hex_seen    = 2'd0;
               hex_invalid = 1'b0;
            end else begin
               parse_phase = jsu_pkg::PH_BODY;
               case (c) inside
                  "\"", "\\", "/": emit(jsu_pkg::KIND_DATA, c, NO_ERROR);
                  "b":             emit(jsu_pkg::KIND_DATA, 8'h08, NO_ERROR);
                  "f":             emit(jsu_pkg::KIND_DATA, 8'h0C, NO_ERROR);
                  "n":             emit(jsu_pkg::KIND_DATA, 8'h0A, NO_ERROR);
                  "r":             emit(jsu_pkg::KIND_DATA, 8'h0D, NO_ERROR);
                  "t":             emit(jsu_pkg::KIND_DATA, 8'h09, NO_ERROR);
                  default:         emit_error(jsu_pkg::ERR_BAD_ESCAPE);
               endcase
            end
         end
         default: begin
            if (eot) begin
               // Running out of text wins over any bad digit already seen.
               emit_error(jsu_pkg::ERR_INCOMPLETE_HEX);
            end else begin
               hv = hex_value(c);
               if (!hv[4]) hex_invalid = 1'b1;
               cp_accum = {cp_accum[11:0], hv[4] ? hv[3:0] : 4'h0};
               if (hex_seen != 2'd3) begin
                  hex_seen = hex_seen + 2'd1;
               end else begin
                  hex_seen = 2'd0;
                  if (hex_invalid) emit_error(jsu_pkg::ERR_BAD_HEX);
                  else if (cp_accum >= 16'hD800 && cp_accum <= 16'hDFFF)
                     emit_error(jsu_pkg::ERR_SURROGATE);
                  else begin
                     parse_phase = jsu_pkg::PH_BODY;
                     emit_utf8(cp_accum);
                  end
               end
            end
         end
      endcase
      if (run_beats.size() != 0) run_beats[run_beats.size() - 1].last = 1'b1;
      beats_due = {beats_due, run_beats};
      run_beats.delete();
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Each accepted result beat is matched against the oldest owed result.
   always @(posedge clock) begin
      decoded_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (beats_due.size() == 0) begin
            $display("%0t: result beat with nothing due: expected none, %s %0d data %h last %b",
                     $time, "actual kind", rsp_tuser, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = beats_due.pop_front();
            check_field("kind", 16'(want.kind), 16'(rsp_tuser));
            check_field("out_byte", 16'(want.data), 16'(rsp_tdata[7:0]));
            check_field("error_code", 16'(want.err), 16'(rsp_tdata[10:8]));
            check_field("tdata padding", 16'h0000, 16'(rsp_tdata[15:11]));
            check_field("last_of_run", 16'(want.last), 16'(rsp_tlast));
         end
      end
   end

   // The result side stalls in random bursts while idling is on.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Sends one byte beat. Called at a falling edge; returns at the falling
   // edge after the beat was taken, with tvalid still high so that the next
   // beat can follow back to back.
   task automatic send_byte(logic [7:0] b, logic eot);
      if (idle_enable && $urandom_range(0, 6) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= eot;
      do @(posedge clock); while (!req_tready);
      predict_unescape(b, eot);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + {4'h0, n};
      return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (hex_value(c) != 5'd0);
      return c;
   endfunction

   function automatic bit is_escape_letter(logic [7:0] c);
      return c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
             c == "n" || c == "r" || c == "t" || c == "u";
   endfunction

   function automatic logic [7:0] simple_escape_letter();
      case ($urandom_range(0, 7))
         0:       return "\"";
         1:       return "\\";
         2:       return "/";
         3:       return "b";
         4:       return "f";
         5:       return "n";
         6:       return "r";
         default: return "t";
      endcase
   endfunction

   function automatic logic [7:0] whitespace_char();
      case ($urandom_range(0, 3))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_CR;
         default: return CH_LF;
      endcase
   endfunction

   // Code points outside the surrogate range, spread over the one-, two-
   // and three-byte encodings with the boundaries favored.
   function automatic logic [15:0] legal_code_point();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(16'h0000, 16'h007F));
         1: return 16'($urandom_range(16'h0080, 16'h07FF));
         2: return 16'($urandom_range(16'h0800, 16'hD7FF));
         3: return 16'($urandom_range(16'hE000, 16'hFFFF));
         default: begin
            case ($urandom_range(0, 7))
               0:       return 16'h0000;
               1:       return 16'h007F;
               2:       return 16'h0080;
               3:       return 16'h07FF;
               4:       return 16'h0800;
               5:       return 16'hD7FF;
               6:       return 16'hE000;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   // A \uXXXX escape; the digit at bad_pos, if below four, is not hex.
   task automatic send_unicode(logic [15:0] cp, int bad_pos);
      send_byte(CH_BACKSLASH, 1'b0);
      send_byte(CH_U, 1'b0);
      for (int i = 0; i < 4; i++) begin
         if (i == bad_pos) send_byte(non_hex_char(), 1'b0);
         else send_byte(hex_char(cp[15 - 4 * i -: 4]), 1'b0);
      end
   endtask

   task automatic send_body_token();
      logic [7:0] c;
      case ($urandom_range(0, 9)) inside
         [0:4]: begin
            do c = 8'($urandom_range(8'h20, 8'hFF));
            while (c == CH_QUOTE || c == CH_BACKSLASH);
            send_byte(c, 1'b0);
         end
         [5:6]: begin
            send_byte(CH_BACKSLASH, 1'b0);
            send_byte(simple_escape_letter(), 1'b0);
         end
         default: send_unicode(legal_code_point(), 4);
      endcase
   endtask

   // A well-formed opening and body, closed by a quote most of the time and
   // by one of the in-string errors otherwise.
   task automatic send_random_string();
      int         ending;
      int         n_hex;
      logic [7:0] c;
      repeat ($urandom_range(0, 2)) send_byte(whitespace_char(), 1'b0);
      send_byte(CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 6)) send_body_token();
      ending = $urandom_range(0, 15);
      if (ending <= 8) begin
         send_byte(CH_QUOTE, 1'b0);
      end else if (ending == 9) begin
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (ending == 10) begin
         send_byte(8'($urandom_range(0, 31)), 1'b0);
      end else if (ending == 11) begin
         send_byte(CH_BACKSLASH, 1'b0);
         do c = 8'($urandom_range(0, 255)); while (is_escape_letter(c));
         send_byte(c, 1'b0);
      end else if (ending == 12) begin
         send_byte(CH_BACKSLASH, 1'b0);
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (ending == 13) begin
         send_unicode(16'($urandom_range(16'hD800, 16'hDFFF)), 4);
      end else if (ending == 14) begin
         send_unicode(legal_code_point(), $urandom_range(0, 3));
      end else begin
         // Text ends in the middle of the hex digits, a bad digit or not.
         send_byte(CH_BACKSLASH, 1'b0);
         send_byte(CH_U, 1'b0);
         n_hex = $urandom_range(0, 3);
         for (int i = 0; i < n_hex; i++) begin
            if ($urandom_range(0, 3) == 0) send_byte(non_hex_char(), 1'b0);
            else send_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
         end
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // End of text and a stray byte while seeking, then every whitespace
   // byte before the opening quote.
   task automatic test_seek_phase();
      send_byte(8'hA5, 1'b1);
      send_byte("x", 1'b0);
      send_byte(CH_SPACE, 1'b0);
      send_byte(CH_TAB, 1'b0);
      send_byte(CH_CR, 1'b0);
      send_byte(CH_LF, 1'b0);
      send_byte(CH_QUOTE, 1'b0);
   endtask

   // Body extremes, a simple escape, the smallest and largest code points
   // and a two-byte one, then the highest control byte.
   task automatic test_body_and_escapes();
      send_byte(8'hFF, 1'b0);
      send_byte(CH_SPACE, 1'b0);
      send_text("\\/\\u0000\\uFfFF\\u07fF");
      send_byte(CH_LAST_CTRL, 1'b0);
   endtask

   // An empty string, a bad digit cut short by the end of text, and the
   // end of text inside a string body.
   task automatic test_escape_errors();
      send_text("\"\"\"\\uG1");
      send_byte(8'h00, 1'b1);
      send_byte(CH_QUOTE, 1'b0);
      send_byte(8'h5A, 1'b1);
   endtask

   // The sender holds off until the block has delivered everything owed.
   task automatic test_pause_until_drained();
      req_tvalid <= 1'b0;
      while (beats_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly well-formed strings with random content, some raw noise.
   task automatic test_random_text(int item_goal);
      while (items_sent < item_goal) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end else begin
            send_random_string();
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence and end of run
   // ---------------------------------------------------------------------

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tuser   = 1'b0;
      parse_phase = jsu_pkg::PH_SEEK;
      cp_accum    = 16'h0000;
      hex_seen    = 2'd0;
      hex_invalid = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_seek_phase();
      test_body_and_escapes();
      test_escape_errors();
      test_pause_until_drained();
      test_random_text(items_sent + 300);

      // The closing stretch runs with both sides at full rate.
      idle_enable = 1'b0;
      test_random_text(items_sent + 60);
      req_tvalid <= 1'b0;

      while (beats_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("tb_json_string_unescape_utf8_top: clean");
      else
         $display("tb_json_string_unescape_utf8_top: errors");
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("tb_json_string_unescape_utf8_top: errors");
      $finish;
   end

endmodule

// File: json_string_unescape_utf8_top.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_top.sv
dv/tb_json_string_unescape_utf8_top.sv
